// ----- design/tolwm_pkg.sv -----
// ----------------------------------------------------------------------------
// tolwm_pkg: shared types and constants of the ticket-ordered lock unit
// Request and result payloads, operation codes, the decoded command that
// passes from the front end to the execution engine, and table sizes.
// ----------------------------------------------------------------------------
package tolwm_pkg;

   localparam int MUTEX_COUNT  = 8;
   localparam int THREAD_SLOTS = 16;

   localparam int OP_W      = 3;
   localparam int MUTEX_W   = 3;
   localparam int THREAD_W  = 4;
   localparam int TICKET_W  = 32;
   localparam int COUNT_W   = 5;
   localparam int COUNT_MAX = 31;
   localparam int FOUND_W   = $clog2(THREAD_SLOTS + 1);

   // Queue depths between the parts; both are powers of two so that the
   // pointers wrap on their own.
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
   localparam int RQ_DEPTH = 2;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // Operation codes carried in the request.
   localparam logic [OP_W-1:0] OP_TRYLOCK  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOCK     = 3'd1;
   localparam logic [OP_W-1:0] OP_WAIT     = 3'd2;
   localparam logic [OP_W-1:0] OP_UNLOCK   = 3'd3;
   localparam logic [OP_W-1:0] OP_WAKE_ONE = 3'd4;
   localparam logic [OP_W-1:0] OP_WAKE_ALL = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [MUTEX_W-1:0]  mutex_index;
      logic [THREAD_W-1:0] thread_index;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic                blocked;
      logic                woken_valid;
      logic [THREAD_W-1:0] woken_thread;
      logic                last;
   } rsp_type;

   // What the engine has to do; KIND_NOP answers with one empty result.
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_TRYLOCK,
      KIND_LOCK,
      KIND_WAIT,
      KIND_UNLOCK,
      KIND_WAKE_ONE,
      KIND_WAKE_ALL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [MUTEX_W-1:0]  mutex_index;
      logic [THREAD_W-1:0] thread_index;
   } cmd_type;

endpackage

// ----- design/tolwm_front.sv -----
// ----------------------------------------------------------------------------
// tolwm_front: request decode and command queue
// Classifies each request into a command and holds it in a two-entry queue
// until the execution engine takes it.
// ----------------------------------------------------------------------------
module tolwm_front import tolwm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type             cq_data_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0] cq_wr_ff;
   logic [CQ_PTR_W-1:0] cq_rd_ff;
   logic [CQ_CNT_W-1:0] cq_count_ff;
   logic [CQ_PTR_W-1:0] cq_wr_in;
   logic [CQ_PTR_W-1:0] cq_rd_in;
   logic [CQ_CNT_W-1:0] cq_count_in;

   cmd_type decoded;
   logic    mutex_ok;
   logic    thread_ok;
   logic    accept;
   logic    take;

   always_comb begin
      mutex_ok             = int'(req_data.mutex_index) < MUTEX_COUNT;
      thread_ok            = int'(req_data.thread_index) < THREAD_SLOTS;
      decoded.mutex_index  = req_data.mutex_index;
      decoded.thread_index = req_data.thread_index;
      decoded.kind         = KIND_NOP;
      unique case (req_data.operation)
         OP_TRYLOCK:  decoded.kind = mutex_ok ? KIND_TRYLOCK : KIND_NOP;
         OP_LOCK:     decoded.kind = (mutex_ok && thread_ok) ? KIND_LOCK : KIND_NOP;
         OP_WAIT:     decoded.kind = (mutex_ok && thread_ok) ? KIND_WAIT : KIND_NOP;
         OP_UNLOCK:   decoded.kind = mutex_ok ? KIND_UNLOCK : KIND_NOP;
         OP_WAKE_ONE: decoded.kind = mutex_ok ? KIND_WAKE_ONE : KIND_NOP;
         OP_WAKE_ALL: decoded.kind = mutex_ok ? KIND_WAKE_ALL : KIND_NOP;
         default:     decoded.kind = KIND_NOP;
      endcase
   end

   assign req_full  = cq_count_ff == CQ_CNT_W'(CQ_DEPTH);
   assign cmd_valid = cq_count_ff != '0;
   assign cmd       = cq_data_ff[cq_rd_ff];
   assign accept    = req_push && !req_full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      cq_wr_in    = accept ? cq_wr_ff + CQ_PTR_W'(1) : cq_wr_ff;
      cq_rd_in    = take ? cq_rd_ff + CQ_PTR_W'(1) : cq_rd_ff;
      cq_count_in = cq_count_ff + CQ_CNT_W'(accept) - CQ_CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cq_wr_ff    <= '0;
         cq_rd_ff    <= '0;
         cq_count_ff <= '0;
      end else begin
         cq_wr_ff    <= cq_wr_in;
         cq_rd_ff    <= cq_rd_in;
         cq_count_ff <= cq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cq_data_ff[cq_wr_ff] <= decoded;
      end
   end

endmodule

// ----- design/tolwm_back.sv -----
// ----------------------------------------------------------------------------
// tolwm_back: lock table, waiter table and wake scanner
// Carries out one command at a time against the mutex and thread tables,
// scanning the thread slots one per cycle for wake operations unless a full
// result queue holds a wake-all scan; results go to a two-entry output queue.
// ----------------------------------------------------------------------------
module tolwm_back import tolwm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_ONE,
      ST_DONE_ONE,
      ST_SCAN_ALL,
      ST_DONE_ALL
   } state_type;

   // Mutex and thread tables.
   logic                lock_held_ff      [MUTEX_COUNT];
   logic [TICKET_W-1:0] next_ticket_ff    [MUTEX_COUNT];
   logic [COUNT_W-1:0]  waiting_count_ff  [MUTEX_COUNT];
   logic                thread_blocked_ff [THREAD_SLOTS];
   logic [MUTEX_W-1:0]  waiter_mutex_ff   [THREAD_SLOTS];
   logic [TICKET_W-1:0] waiter_ticket_ff  [THREAD_SLOTS];

   // Sequencer.
   state_type           state_ff,  state_in;
   logic [MUTEX_W-1:0]  mutex_ff,  mutex_in;
   logic [THREAD_W-1:0] slot_ff,   slot_in;
   logic [FOUND_W-1:0]  found_ff,  found_in;
   logic                have_ff,   have_in;
   logic [TICKET_W-1:0] best_ff,   best_in;
   logic [THREAD_W-1:0] win_ff,    win_in;

   // Result queue.
   rsp_type             rq_data_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] rq_wr_ff;
   logic [RQ_PTR_W-1:0] rq_rd_ff;
   logic [RQ_CNT_W-1:0] rq_count_ff;
   logic                rq_full;
   logic                rq_push;
   rsp_type             rq_push_data;
   logic                rq_take;

   // Table write controls.
   logic                lock_we;
   logic                lock_wd;
   logic                block_we;
   logic                count_we;
   logic [COUNT_W-1:0]  count_wd;
   logic                clear_we;
   logic [THREAD_W-1:0] clear_idx;
   logic                slot_match;
   logic                last_slot;
   logic [TICKET_W-1:0] slot_ticket;

   assign rq_full     = rq_count_ff == RQ_CNT_W'(RQ_DEPTH);
   assign rsp_empty   = rq_count_ff == '0;
   assign rsp_data    = rq_data_ff[rq_rd_ff];
   assign rq_take     = rsp_pop && !rsp_empty;
   assign slot_ticket = waiter_ticket_ff[slot_ff];
   assign slot_match  = thread_blocked_ff[slot_ff] && (waiter_mutex_ff[slot_ff] == mutex_ff);
   assign last_slot   = slot_ff == THREAD_W'(THREAD_SLOTS - 1);

   always_comb begin
      state_in          = state_ff;
      mutex_in          = mutex_ff;
      slot_in           = slot_ff;
      found_in          = found_ff;
      have_in           = have_ff;
      best_in           = best_ff;
      win_in            = win_ff;
      cmd_pop           = 1'b0;
      rq_push           = 1'b0;
      rq_push_data      = '0;
      rq_push_data.last = 1'b1;
      lock_we           = 1'b0;
      lock_wd           = 1'b0;
      block_we          = 1'b0;
      count_we          = 1'b0;
      count_wd          = '0;
      clear_we          = 1'b0;
      clear_idx         = slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rq_full) begin
               cmd_pop  = 1'b1;
               mutex_in = cmd.mutex_index;
               unique case (cmd.kind)
                  KIND_TRYLOCK, KIND_LOCK: begin
                     rq_push = 1'b1;
                     if (!lock_held_ff[cmd.mutex_index]) begin
                        lock_we              = 1'b1;
                        lock_wd              = 1'b1;
                        rq_push_data.granted = 1'b1;
                     end else if (cmd.kind == KIND_LOCK) begin
                        block_we             = 1'b1;
                        rq_push_data.blocked = 1'b1;
                     end
                  end
                  KIND_WAIT: begin
                     block_we             = 1'b1;
                     rq_push              = 1'b1;
                     rq_push_data.blocked = 1'b1;
                  end
                  KIND_UNLOCK, KIND_WAKE_ONE, KIND_WAKE_ALL: begin
                     if (cmd.kind == KIND_UNLOCK) begin
                        lock_we = 1'b1;
                     end
                     if (waiting_count_ff[cmd.mutex_index] == '0) begin
                        rq_push = 1'b1;
                     end else begin
                        slot_in  = '0;
                        found_in = '0;
                        have_in  = 1'b0;
                        state_in = (cmd.kind == KIND_WAKE_ALL) ? ST_SCAN_ALL : ST_SCAN_ONE;
                     end
                  end
                  default: begin
                     rq_push = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN_ONE: begin
            if (slot_match) begin
               found_in = found_ff + FOUND_W'(1);
               if (!have_ff || slot_ticket < best_ff) begin
                  have_in = 1'b1;
                  best_in = slot_ticket;
                  win_in  = slot_ff;
               end
            end
            if (last_slot) begin
               state_in = ST_DONE_ONE;
            end else begin
               slot_in = slot_ff + THREAD_W'(1);
            end
         end
         ST_DONE_ONE: begin
            if (!rq_full) begin
               count_we = 1'b1;
               count_wd = (int'(found_ff) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                        : COUNT_W'(found_ff);
               rq_push  = 1'b1;
               if (have_ff) begin
                  clear_we                  = 1'b1;
                  clear_idx                 = win_ff;
                  rq_push_data.woken_valid  = 1'b1;
                  rq_push_data.woken_thread = win_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_ALL: begin
            // A matching slot releases the previously held waiter, so it must
            // wait for room in the result queue.
            if (!(slot_match && have_ff && rq_full)) begin
               if (slot_match) begin
                  clear_we = 1'b1;
                  if (have_ff) begin
                     rq_push                   = 1'b1;
                     rq_push_data.woken_valid  = 1'b1;
                     rq_push_data.woken_thread = win_ff;
                     rq_push_data.last         = 1'b0;
                  end
                  have_in = 1'b1;
                  win_in  = slot_ff;
               end
               if (last_slot) begin
                  state_in = ST_DONE_ALL;
               end else begin
                  slot_in = slot_ff + THREAD_W'(1);
               end
            end
         end
         ST_DONE_ALL: begin
            if (!rq_full) begin
               count_we = 1'b1;
               rq_push  = 1'b1;
               if (have_ff) begin
                  rq_push_data.woken_valid  = 1'b1;
                  rq_push_data.woken_thread = win_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mutex_ff <= '0;
         slot_ff  <= '0;
         found_ff <= '0;
         have_ff  <= 1'b0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mutex_ff <= mutex_in;
         slot_ff  <= slot_in;
         found_ff <= found_in;
         have_ff  <= have_in;
         win_ff   <= win_in;
      end
      best_ff <= best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MUTEX_COUNT; i++) begin
            lock_held_ff[i]     <= 1'b0;
            next_ticket_ff[i]   <= '0;
            waiting_count_ff[i] <= '0;
         end
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            thread_blocked_ff[i] <= 1'b0;
            waiter_mutex_ff[i]   <= '0;
         end
      end else begin
         if (lock_we) begin
            lock_held_ff[cmd.mutex_index] <= lock_wd;
         end
         if (block_we) begin
            thread_blocked_ff[cmd.thread_index] <= 1'b1;
            waiter_mutex_ff[cmd.thread_index]   <= cmd.mutex_index;
            next_ticket_ff[cmd.mutex_index]     <=
               next_ticket_ff[cmd.mutex_index] + TICKET_W'(1);
            if (waiting_count_ff[cmd.mutex_index] < COUNT_W'(COUNT_MAX)) begin
               waiting_count_ff[cmd.mutex_index] <=
                  waiting_count_ff[cmd.mutex_index] + COUNT_W'(1);
            end
         end
         if (count_we) begin
            waiting_count_ff[mutex_ff] <= count_wd;
         end
         if (clear_we) begin
            thread_blocked_ff[clear_idx] <= 1'b0;
            waiter_mutex_ff[clear_idx]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (block_we) begin
         waiter_ticket_ff[cmd.thread_index] <= next_ticket_ff[cmd.mutex_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_push ? rq_wr_ff + RQ_PTR_W'(1) : rq_wr_ff;
         rq_rd_ff    <= rq_take ? rq_rd_ff + RQ_PTR_W'(1) : rq_rd_ff;
         rq_count_ff <= rq_count_ff + RQ_CNT_W'(rq_push) - RQ_CNT_W'(rq_take);
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_data_ff[rq_wr_ff] <= rq_push_data;
      end
   end

`ifndef SYNTH
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      rq_count_ff <= RQ_CNT_W'(RQ_DEPTH))
      else $error("result queue holds more entries than it has");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid && !rq_full)
      else $error("command taken while the engine was busy");

   a_all_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_ALL) && rq_push |-> !rq_push_data.last && !rq_full)
      else $error("wake-all result during the scan marked final");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE_ONE) || (state_ff == ST_DONE_ALL)) && !rq_full
      |=> state_ff == ST_IDLE)
      else $error("engine did not return to idle after finishing a wake");

   a_wake_blocked: assert property (@(posedge clock) disable iff (reset)
      clear_we |-> thread_blocked_ff[clear_idx] && (waiter_mutex_ff[clear_idx] == mutex_ff))
      else $error("woke a thread that was not waiting on this mutex");
`endif

endmodule

// ----- design/ticket_ordered_lock_wait_manager.sv -----
// ----------------------------------------------------------------------------
// ticket_ordered_lock_wait_manager: ticket-ordered mutex and wait-queue unit
// Manages eight mutexes and sixteen thread slots; grants, blocks and wakes
// threads in ticket order.
// ----------------------------------------------------------------------------
//
//  Channel    Ports                               Transfer
//  request    req_push, req_full, req_data        push high and full low
//  result     rsp_pop, rsp_empty, rsp_data        pop high and empty low
//
// Trylock, lock and wait are done in the engine's idle state, as are unlock and the
// wake operations when the mutex has no waiters counted.
// Otherwise a wake scans every thread slot, one per cycle unless the result
// queue stalls a wake-all scan, and then finishes in a done state.
// A request is registered in the command queue and in the result queue on its way;
// two requests may queue ahead of the engine and two results after it.
// Reset is synchronous and clears all locks, tickets, counts and waiters.
// A full result queue stalls the engine, and in wake-all it stalls the scan
// at the next waiter found until a result is popped.
//
module ticket_ordered_lock_wait_manager import tolwm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // Decoded command passed from the front end to the engine.
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // The front end classifies each request (invalid operations and indexes
   // become an empty-result command) and buffers it, so requests are taken
   // while the engine is still scanning.
   tolwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // The engine owns all lock and waiter state and produces every result,
   // ending each request with a result that has last set.
   tolwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the ticket-ordered lock and wait-queue unit
// Requests are pushed into the unit while results are popped under random
// stalls. Every accepted request runs through a predictor of the lock, ticket
// and waiter tables, which queues the expected results. Each popped result
// is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tolwm_pkg::*;

   // Operation codes that the unit does not define; they must be answered
   // with one empty result and leave the tables alone.
   localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

   // Quiet stretch after the last expected result; it outlasts a wake's scan
   // of all sixteen slots and the draining of both queues.
   localparam int DRAIN_CYCLES = 50;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   // Random idling on both channels; cleared for the closing stretch.
   logic idling_on = 1'b1;

   // Predictor's copy of the unit's tables, at the unit's own widths.
   logic                lock_taken      [MUTEX_COUNT]  = '{default: '0};
   logic [TICKET_W-1:0] ticket_next     [MUTEX_COUNT]  = '{default: '0};
   logic [COUNT_W-1:0]  waiters_counted [MUTEX_COUNT]  = '{default: '0};
   logic                slot_blocked    [THREAD_SLOTS] = '{default: '0};
   logic [MUTEX_W-1:0]  slot_mutex      [THREAD_SLOTS] = '{default: '0};
   logic [TICKET_W-1:0] slot_ticket     [THREAD_SLOTS] = '{default: '0};

   // Results still owed by the unit, oldest first.
   rsp_type awaited_results[$];
   int      result_errors = 0;
   int      pop_stall_left = 0;

   ticket_ordered_lock_wait_manager i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // A blocked thread takes the mutex's next ticket. A thread that is already
   // blocked elsewhere simply has its entry overwritten, which leaves the
   // other mutex's waiting count too high until its next scan.
   function automatic void block_waiter(input logic [MUTEX_W-1:0] m,
                                        input logic [THREAD_W-1:0] t);
      slot_blocked[t] = 1'b1;
      slot_mutex[t]   = m;
      slot_ticket[t]  = ticket_next[m];
      ticket_next[m]  = ticket_next[m] + 1'b1;
      if (waiters_counted[m] < COUNT_MAX) begin
         waiters_counted[m] = waiters_counted[m] + 1'b1;
      end
   endfunction

   // Wakes the waiter with the lowest ticket, lowest slot on a tie. The count
   // is rewritten with the number of waiters found, the woken one included,
   // and a zero count skips the scan altogether.
   function automatic void wake_lowest_ticket(input logic [MUTEX_W-1:0] m);
      rsp_type             res;
      int                  found;
      bit                  have;
      logic [TICKET_W-1:0] best;
      int                  winner;
      res       = '0;
      res.last  = 1'b1;
      found     = 0;
      have      = 1'b0;
      best      = '0;
      winner    = 0;
      if (waiters_counted[m] != '0) begin
         for (int s = 0; s < THREAD_SLOTS; s++) begin
            if (slot_blocked[s] && slot_mutex[s] == m) begin
               found++;
               if (!have || slot_ticket[s] < best) begin
                  have   = 1'b1;
                  best   = slot_ticket[s];
                  winner = s;
               end
            end
         end
         waiters_counted[m] = (found > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(found);
         if (have) begin
            slot_blocked[winner] = 1'b0;
            slot_mutex[winner]   = '0;
            res.woken_valid      = 1'b1;
            res.woken_thread     = THREAD_W'(winner);
         end
      end
      awaited_results.push_back(res);
   endfunction

   // Updates the tables for one accepted request and queues what it owes.
   function automatic void apply_lock_request(input req_type r);
      rsp_type res;
      int      n;
      res      = '0;
      res.last = 1'b1;
      n        = 0;
      case (r.operation)
         OP_TRYLOCK, OP_LOCK: begin
            if (!lock_taken[r.mutex_index]) begin
               lock_taken[r.mutex_index] = 1'b1;
               res.granted = 1'b1;
            end else if (r.operation == OP_LOCK) begin
               block_waiter(r.mutex_index, r.thread_index);
               res.blocked = 1'b1;
            end
            awaited_results.push_back(res);
         end
         OP_WAIT: begin
            block_waiter(r.mutex_index, r.thread_index);
            res.blocked = 1'b1;
            awaited_results.push_back(res);
         end
         OP_UNLOCK: begin
            lock_taken[r.mutex_index] = 1'b0;
            wake_lowest_ticket(r.mutex_index);
         end
         OP_WAKE_ONE: begin
            wake_lowest_ticket(r.mutex_index);
         end
         OP_WAKE_ALL: begin
            // Every waiter of the mutex is reported in slot order; only the
            // final result carries the last flag.
            if (waiters_counted[r.mutex_index] != '0) begin
               for (int s = 0; s < THREAD_SLOTS; s++) begin
                  if (slot_blocked[s] && slot_mutex[s] == r.mutex_index) begin
                     slot_blocked[s]  = 1'b0;
                     slot_mutex[s]    = '0;
                     res              = '0;
                     res.woken_valid  = 1'b1;
                     res.woken_thread = THREAD_W'(s);
                     awaited_results.push_back(res);
                     n++;
                  end
               end
               waiters_counted[r.mutex_index] = '0;
            end
            if (n == 0) begin
               res      = '0;
               res.last = 1'b1;
               awaited_results.push_back(res);
            end else begin
               awaited_results[$].last = 1'b1;
            end
         end
         default: begin
            awaited_results.push_back(res);
         end
      endcase
   endfunction

   // Offers one request and holds it until the unit takes it. Called just
   // after a rising edge; push stays high when the next request follows
   // straight on, so it is never lowered and raised in the same step.
   task automatic push_request(input logic [OP_W-1:0] op,
                               input logic [MUTEX_W-1:0] m,
                               input logic [THREAD_W-1:0] t);
      req_type r;
      r.operation    = op;
      r.mutex_index  = m;
      r.thread_index = t;
      req_data <= r;
      req_push <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_full);
      apply_lock_request(r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Traffic mostly on three mutexes so that locks are contended and queues
   // of waiters build up; now and then any mutex or a reserved code.
   task automatic push_random_request();
      int               sel;
      logic [OP_W-1:0]  op;
      logic [MUTEX_W-1:0] m;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         op = OP_LOCK;
      end else if (sel < 35) begin
         op = OP_TRYLOCK;
      end else if (sel < 50) begin
         op = OP_WAIT;
      end else if (sel < 70) begin
         op = OP_UNLOCK;
      end else if (sel < 85) begin
         op = OP_WAKE_ONE;
      end else if (sel < 95) begin
         op = OP_WAKE_ALL;
      end else if (sel < 97) begin
         op = OP_RESERVED_A;
      end else begin
         op = OP_RESERVED_B;
      end
      m = ($urandom_range(0, 3) == 0) ? MUTEX_W'($urandom_range(0, MUTEX_COUNT - 1))
                                      : MUTEX_W'($urandom_range(0, 2));
      push_request(op, m, THREAD_W'($urandom_range(0, THREAD_SLOTS - 1)));
   endtask

   // Grants, contention, wakes on empty queues, stale counts left behind by
   // re-blocked threads, reserved codes and the highest mutex and thread.
   task automatic test_directed_locking();
      push_request(OP_TRYLOCK,    3'd0, 4'd0);
      push_request(OP_TRYLOCK,    3'd0, 4'd1);
      push_request(OP_LOCK,       3'd0, 4'd2);
      push_request(OP_LOCK,       3'd0, 4'd3);
      push_request(OP_UNLOCK,     3'd0, 4'd0);
      push_request(OP_WAKE_ONE,   3'd0, 4'd0);
      push_request(OP_WAKE_ONE,   3'd0, 4'd0);
      push_request(OP_WAKE_ALL,   3'd0, 4'd0);
      push_request(OP_UNLOCK,     3'd0, 4'd0);
      push_request(OP_LOCK,       3'd7, 4'd15);
      push_request(OP_WAIT,       3'd7, 4'd15);
      push_request(OP_WAIT,       3'd7, 4'd0);
      push_request(OP_WAIT,       3'd7, 4'd8);
      push_request(OP_WAIT,       3'd3, 4'd8);
      push_request(OP_WAKE_ALL,   3'd7, 4'd0);
      push_request(OP_WAKE_ONE,   3'd3, 4'd0);
      push_request(OP_WAIT,       3'd2, 4'd4);
      push_request(OP_WAIT,       3'd2, 4'd5);
      push_request(OP_WAIT,       3'd1, 4'd5);
      push_request(OP_WAKE_ONE,   3'd2, 4'd0);
      push_request(OP_WAKE_ONE,   3'd2, 4'd0);
      push_request(OP_RESERVED_A, 3'd5, 4'd10);
      push_request(OP_RESERVED_B, 3'd7, 4'd15);
      push_request(OP_WAKE_ALL,   3'd1, 4'd0);
      push_request(OP_UNLOCK,     3'd7, 4'd0);
   endtask

   // More waits than the count can hold, with every slot blocked, so that the
   // count saturates and wake-all reports all sixteen threads at once.
   task automatic test_count_saturation();
      for (int t = 0; t < THREAD_SLOTS; t++) begin
         push_request(OP_WAIT, 3'd5, THREAD_W'(t));
      end
      repeat (20) push_request(OP_WAIT, 3'd5, THREAD_W'($urandom_range(0, THREAD_SLOTS - 1)));
      push_request(OP_WAKE_ALL, 3'd5, 4'd0);
      push_request(OP_WAKE_ONE, 3'd5, 4'd0);
      repeat (6) push_request(OP_WAIT, 3'd6, THREAD_W'($urandom_range(0, THREAD_SLOTS - 1)));
      repeat (3) push_request(OP_WAKE_ONE, 3'd6, 4'd0);
   endtask

   task automatic test_random_traffic();
      repeat (120) push_random_request();
   endtask

   // Closing stretch without idling on either side, so requests and results
   // move back to back.
   task automatic test_back_to_back();
      idling_on <= 1'b0;
      repeat (40) push_random_request();
   endtask

   // Result side: check each popped result, then decide whether to stall.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_results.size() == 0) begin
            result_errors++;
            if (result_errors <= 10) begin
               $display("Unexpected result: g=%0d b=%0d wv=%0d wt=%0d l=%0d",
                        rsp_data.granted, rsp_data.blocked, rsp_data.woken_valid,
                        rsp_data.woken_thread, rsp_data.last);
            end
         end else begin
            if (rsp_data.granted      !== awaited_results[0].granted     ||
                rsp_data.blocked      !== awaited_results[0].blocked     ||
                rsp_data.woken_valid  !== awaited_results[0].woken_valid ||
                rsp_data.woken_thread !== awaited_results[0].woken_thread ||
                rsp_data.last         !== awaited_results[0].last) begin
               result_errors++;
               if (result_errors <= 10) begin
                  $display("Result mismatch: expected g=%0d b=%0d wv=%0d wt=%0d l=%0d, got g=%0d b=%0d wv=%0d wt=%0d l=%0d",
                           awaited_results[0].granted, awaited_results[0].blocked,
                           awaited_results[0].woken_valid, awaited_results[0].woken_thread,
                           awaited_results[0].last, rsp_data.granted, rsp_data.blocked,
                           rsp_data.woken_valid, rsp_data.woken_thread, rsp_data.last);
               end
            end
            void'(awaited_results.pop_front());
         end
      end
      if (pop_stall_left > 0) begin
         pop_stall_left--;
         rsp_pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         pop_stall_left = $urandom_range(1, 14) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_locking();
      test_count_saturation();
      test_random_traffic();
      test_back_to_back();
      req_push <= 1'b0;
      while (awaited_results.size() != 0) begin
         @(posedge clock);
      end
      // Any stray result after the last expected one is caught by the checker.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (result_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tolwm_pkg.sv
design/tolwm_front.sv
design/tolwm_back.sv
design/ticket_ordered_lock_wait_manager.sv
verif/tb_top.sv
